// ===== sv/aed_pkg.sv =====
// ----------------------------------------------------------------------------
// aed_pkg
// Types and constants shared by the escape decoder core and its top level.
// ----------------------------------------------------------------------------
package aed_pkg;

  // result kinds
  typedef enum logic [3:0] {
    KIND_TEXT        = 4'd0,
    KIND_UP          = 4'd1,
    KIND_DOWN        = 4'd2,
    KIND_RIGHT       = 4'd3,
    KIND_LEFT        = 4'd4,
    KIND_NEXT_LINE   = 4'd5,
    KIND_PREV_LINE   = 4'd6,
    KIND_COLUMN      = 4'd7,
    KIND_POSITION    = 4'd8,
    KIND_ERASE_DISP  = 4'd9,
    KIND_ERASE_LINE  = 4'd10
  } aed_kind_e;

  // parser modes
  typedef enum logic [1:0] {
    MODE_GROUND = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2,
    MODE_OTHER  = 2'd3
  } aed_mode_e;

  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
    logic       overline;
    logic       strike;
    logic       underline;
    logic       italic;
    logic [1:0] weight;
  } aed_attr_t;

  typedef struct packed {
    logic        emit;
    aed_kind_e   kind;
    logic [7:0]  char_byte;
    logic [15:0] first_value;
    logic [15:0] second_value;
  } aed_result_t;

  localparam logic [3:0] COLOUR_DEFAULT = 4'd8;
  localparam logic [1:0] WEIGHT_NORMAL  = 2'd0;
  localparam logic [1:0] WEIGHT_BOLD    = 2'd1;
  localparam logic [1:0] WEIGHT_FAINT   = 2'd2;

  localparam aed_attr_t ATTR_DEFAULT = '{
    bg:        COLOUR_DEFAULT,
    fg:        COLOUR_DEFAULT,
    overline:  1'b0,
    strike:    1'b0,
    underline: 1'b0,
    italic:    1'b0,
    weight:    WEIGHT_NORMAL
  };

  localparam logic [7:0] CHAR_ESC       = 8'h1B;
  localparam logic [7:0] CHAR_BS        = 8'h08;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_AT        = 8'h40;
  localparam logic [7:0] CHAR_BRACKET   = 8'h5B;
  localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;

  // select graphic rendition codes
  localparam int unsigned SGR_RESET         = 0;
  localparam int unsigned SGR_BOLD          = 1;
  localparam int unsigned SGR_FAINT         = 2;
  localparam int unsigned SGR_ITALIC        = 3;
  localparam int unsigned SGR_UNDERLINE     = 4;
  localparam int unsigned SGR_STRIKE        = 9;
  localparam int unsigned SGR_NORMAL_WEIGHT = 22;
  localparam int unsigned SGR_NO_UNDERLINE  = 24;
  localparam int unsigned SGR_NO_STRIKE     = 29;
  localparam int unsigned SGR_FG_FIRST      = 30;
  localparam int unsigned SGR_FG_LAST       = 37;
  localparam int unsigned SGR_FG_DEFAULT    = 39;
  localparam int unsigned SGR_BG_FIRST      = 40;
  localparam int unsigned SGR_BG_LAST       = 47;
  localparam int unsigned SGR_BG_DEFAULT    = 49;
  localparam int unsigned SGR_OVERLINE      = 53;
  localparam int unsigned SGR_NO_OVERLINE   = 55;

endpackage

// ===== sv/aed_core.sv =====
// ----------------------------------------------------------------------------
// aed_core
// Parser state and per-byte update: sequence tracking, parameter capture,
// command decode and display attribute updates.
// ----------------------------------------------------------------------------
module aed_core import aed_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output aed_result_t result_o,
  output aed_attr_t   attr_o
);

  localparam logic [VALUE_BITS-1:0] VAL_ZERO = '0;
  localparam logic [VALUE_BITS-1:0] VAL_ONE  = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] VAL_TWO  = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] VAL_MAX  = '1;

  aed_mode_e             mode_q, mode_d;
  logic [VALUE_BITS-1:0] one_q, one_d;
  logic [VALUE_BITS-1:0] two_q, two_d;
  logic [VALUE_BITS-1:0] sec_q, sec_d;
  logic                  sep_q, sep_d;
  logic                  digit_q, digit_d;
  logic                  sep2_q, sep2_d;
  logic                  invalid_q, invalid_d;
  aed_attr_t             attr_q, attr_d;
  aed_attr_t             pend_q, pend_d;

  logic                  is_final;
  logic                  is_digit;
  logic [VALUE_BITS-1:0] sec_res0;
  logic [VALUE_BITS-1:0] sec_res1;
  logic                  single_empty;
  logic [VALUE_BITS-1:0] single1;
  logic [VALUE_BITS-1:0] single0;
  logic [VALUE_BITS-1:0] erase_mode;
  logic [VALUE_BITS+3:0] prod;
  logic [VALUE_BITS-1:0] row;
  logic [VALUE_BITS-1:0] col;

  function automatic aed_attr_t sgr_apply(aed_attr_t a, logic [VALUE_BITS-1:0] c);
    aed_attr_t r;
    r = a;
    if (c == VALUE_BITS'(SGR_RESET)) begin
      r = ATTR_DEFAULT;
    end else if (c == VALUE_BITS'(SGR_BOLD)) begin
      r.weight = WEIGHT_BOLD;
    end else if (c == VALUE_BITS'(SGR_FAINT)) begin
      r.weight = WEIGHT_FAINT;
    end else if (c == VALUE_BITS'(SGR_ITALIC)) begin
      r.italic = 1'b1;
    end else if (c == VALUE_BITS'(SGR_UNDERLINE)) begin
      r.underline = 1'b1;
    end else if (c == VALUE_BITS'(SGR_STRIKE)) begin
      r.strike = 1'b1;
    end else if (c == VALUE_BITS'(SGR_NORMAL_WEIGHT)) begin
      r.weight = WEIGHT_NORMAL;
    end else if (c == VALUE_BITS'(SGR_NO_UNDERLINE)) begin
      r.underline = 1'b0;
    end else if (c == VALUE_BITS'(SGR_NO_STRIKE)) begin
      r.strike = 1'b0;
    end else if (c >= VALUE_BITS'(SGR_FG_FIRST) && c <= VALUE_BITS'(SGR_FG_LAST)) begin
      r.fg = 4'(c - VALUE_BITS'(SGR_FG_FIRST));
    end else if (c == VALUE_BITS'(SGR_FG_DEFAULT)) begin
      r.fg = COLOUR_DEFAULT;
    end else if (c >= VALUE_BITS'(SGR_BG_FIRST) && c <= VALUE_BITS'(SGR_BG_LAST)) begin
      r.bg = 4'(c - VALUE_BITS'(SGR_BG_FIRST));
    end else if (c == VALUE_BITS'(SGR_BG_DEFAULT)) begin
      r.bg = COLOUR_DEFAULT;
    end else if (c == VALUE_BITS'(SGR_OVERLINE)) begin
      r.overline = 1'b1;
    end else if (c == VALUE_BITS'(SGR_NO_OVERLINE)) begin
      r.overline = 1'b0;
    end
    return r;
  endfunction

  assign is_final = (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                    (byte_i >= 8'h61 && byte_i <= 8'h7A) || (byte_i == CHAR_AT);
  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);

  assign sec_res0 = invalid_q ? VAL_ZERO : (digit_q ? sec_q : VAL_ZERO);
  assign sec_res1 = invalid_q ? VAL_ZERO : (digit_q ? sec_q : VAL_ONE);

  assign single_empty = !sep_q && !digit_q && !invalid_q;
  assign single1 = single_empty ? VAL_ONE : (sep_q ? VAL_ZERO : sec_res0);
  assign single0 = single_empty ? VAL_ZERO : (sep_q ? VAL_ZERO : sec_res0);
  assign erase_mode = (single0 > VAL_TWO) ? VAL_ZERO : single0;

  assign prod = ({4'b0, sec_q} << 3) + ({4'b0, sec_q} << 1) +
                (VALUE_BITS+4)'(byte_i[3:0]);

  always_comb begin
    if (!sep_q) begin
      row = sec_res1;
      col = VAL_ONE;
    end else if (!sep2_q) begin
      row = one_q;
      col = sec_res1;
    end else begin
      row = one_q;
      col = two_q;
    end
  end

  // next state
  always_comb begin
    mode_d    = mode_q;
    one_d     = one_q;
    two_d     = two_q;
    sec_d     = sec_q;
    sep_d     = sep_q;
    digit_d   = digit_q;
    sep2_d    = sep2_q;
    invalid_d = invalid_q;
    attr_d    = attr_q;
    pend_d    = pend_q;
    unique case (mode_q)
      MODE_GROUND: begin
        if (byte_i == CHAR_ESC) begin
          mode_d    = MODE_ESC;
          one_d     = VAL_ZERO;
          two_d     = VAL_ZERO;
          sec_d     = VAL_ZERO;
          sep_d     = 1'b0;
          digit_d   = 1'b0;
          sep2_d    = 1'b0;
          invalid_d = 1'b0;
        end
      end
      MODE_ESC: begin
        if (byte_i == CHAR_BRACKET) begin
          mode_d = MODE_CSI;
          pend_d = attr_q;
        end else if (is_final) begin
          mode_d = MODE_GROUND;
        end else begin
          mode_d = MODE_OTHER;
        end
      end
      MODE_OTHER: begin
        if (is_final) begin
          mode_d = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        priority if (is_digit) begin
          if (!invalid_q) begin
            sec_d   = (|prod[VALUE_BITS+3:VALUE_BITS]) ? VAL_MAX : prod[VALUE_BITS-1:0];
            digit_d = 1'b1;
          end
        end else if (byte_i == CHAR_SEMICOLON) begin
          if (!sep_q) begin
            one_d = sec_res1;
          end else if (!sep2_q) begin
            two_d  = sec_res1;
            sep2_d = 1'b1;
          end
          pend_d    = sgr_apply(pend_q, sec_res0);
          sep_d     = 1'b1;
          sec_d     = VAL_ZERO;
          digit_d   = 1'b0;
          invalid_d = 1'b0;
        end else if (is_final) begin
          mode_d = MODE_GROUND;
          if (byte_i == 8'h6D) begin
            pend_d = sgr_apply(pend_q, sec_res0);
            attr_d = sgr_apply(pend_q, sec_res0);
          end
        end else begin
          invalid_d = 1'b1;
        end
      end
      default: mode_d = MODE_GROUND;
    endcase
  end

  // result decode
  always_comb begin
    result_o = '{emit: 1'b0, kind: KIND_TEXT, char_byte: 8'h00,
                 first_value: 16'h0000, second_value: 16'h0000};
    unique case (mode_q)
      MODE_GROUND: begin
        if (byte_i == CHAR_BS) begin
          result_o.emit        = 1'b1;
          result_o.kind        = KIND_LEFT;
          result_o.first_value = 16'd1;
        end else if (byte_i != CHAR_ESC && byte_i != CHAR_CR) begin
          result_o.emit      = 1'b1;
          result_o.char_byte = byte_i;
        end
      end
      MODE_CSI: begin
        result_o.emit        = 1'b1;
        result_o.first_value = 16'(single1);
        unique case (byte_i)
          8'h41: result_o.kind = KIND_UP;
          8'h42: result_o.kind = KIND_DOWN;
          8'h43: result_o.kind = KIND_RIGHT;
          8'h44: result_o.kind = KIND_LEFT;
          8'h45: result_o.kind = KIND_NEXT_LINE;
          8'h46: result_o.kind = KIND_PREV_LINE;
          8'h47: result_o.kind = KIND_COLUMN;
          8'h48, 8'h66: begin
            result_o.kind         = KIND_POSITION;
            result_o.first_value  = 16'(row);
            result_o.second_value = 16'(col);
          end
          8'h4A: begin
            result_o.kind        = KIND_ERASE_DISP;
            result_o.first_value = 16'(erase_mode);
          end
          8'h4B: begin
            result_o.kind        = KIND_ERASE_LINE;
            result_o.first_value = 16'(erase_mode);
          end
          default: begin
            result_o.emit        = 1'b0;
            result_o.first_value = 16'h0000;
          end
        endcase
      end
      default: result_o.emit = 1'b0;
    endcase
  end

  assign attr_o = attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_GROUND;
      one_q     <= '0;
      two_q     <= '0;
      sec_q     <= '0;
      sep_q     <= 1'b0;
      digit_q   <= 1'b0;
      sep2_q    <= 1'b0;
      invalid_q <= 1'b0;
      attr_q    <= ATTR_DEFAULT;
      pend_q    <= ATTR_DEFAULT;
    end else if (step_i) begin
      mode_q    <= mode_d;
      one_q     <= one_d;
      two_q     <= two_d;
      sec_q     <= sec_d;
      sep_q     <= sep_d;
      digit_q   <= digit_d;
      sep2_q    <= sep2_d;
      invalid_q <= invalid_d;
      attr_q    <= attr_d;
      pend_q    <= pend_d;
    end
  end

endmodule

// ===== sv/ansi_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_decoder
// Decodes a terminal byte stream into text and cursor/erase commands, with
// the current display attributes attached to every result.
// ----------------------------------------------------------------------------
// One byte is taken per transaction and may be followed by another in the
// next cycle. A byte passes through an input register, is decoded by the
// core, and its result (if any) lands in the output register; sustained
// rate is one byte per cycle, limited only by downstream stall. Bytes that
// give no result (CR, escape sequence bytes, SGR updates) still move
// through the input register without loading the output register.
// Parameter values saturate at 2^VALUE_BITS-1 and are reported in 16 bits.
module ansi_escape_decoder import aed_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  char_byte_o,
  output logic [15:0] first_value_o,
  output logic [15:0] second_value_o,
  output logic [1:0]  weight_o,
  output logic        italic_on_o,
  output logic        underline_on_o,
  output logic        strike_on_o,
  output logic        overline_on_o,
  output logic [3:0]  fg_colour_o,
  output logic [3:0]  bg_colour_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  aed_result_t res_q;
  aed_attr_t   res_attr_q;
  aed_result_t res;
  aed_attr_t   attr;
  logic        step;
  logic        accept;

  assign step       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !step);
  assign out_valid_d = (out_valid_q && out_stall_i) || (step && res.emit);

  aed_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res),
    .attr_o   (attr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
    end
    if (step && res.emit) begin
      res_q      <= res;
      res_attr_q <= attr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign char_byte_o    = res_q.char_byte;
  assign first_value_o  = res_q.first_value;
  assign second_value_o = res_q.second_value;
  assign weight_o       = res_attr_q.weight;
  assign italic_on_o    = res_attr_q.italic;
  assign underline_on_o = res_attr_q.underline;
  assign strike_on_o    = res_attr_q.strike;
  assign overline_on_o  = res_attr_q.overline;
  assign fg_colour_o    = res_attr_q.fg;
  assign bg_colour_o    = res_attr_q.bg;

endmodule
